[rtl/core/tpt_pkg.sv]
`default_nettype none

package tpt_pkg;

	// Field and register widths.
	localparam int TIME_W  = 32;
	localparam int DEB_W   = 16;
	localparam int PPR_W   = 5;
	localparam int RPM_W   = 24;
	localparam int IDX_W   = 2;
	localparam int DATA_W  = 32;

	// Denominator pulses_per_rev * period and the restoring divider around it.
	localparam int DEN_W     = PPR_W + TIME_W;
	localparam int NUM_W     = 30;
	localparam int DIV_STEPS = NUM_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

	// 60,000,000 * 16 for a result in Q4.
	localparam logic [NUM_W-1:0] RPM_Q4_NUM = NUM_W'(960000000);
	localparam logic [RPM_W-1:0] RPM_MAX    = {RPM_W{1'b1}};

	// Queue between the front and back ends.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Reset values of the configuration registers.
	localparam logic [DEB_W-1:0]  DEBOUNCE_RST = DEB_W'(2000);
	localparam logic [TIME_W-1:0] TIMEOUT_RST  = TIME_W'(1000000);
	localparam logic [PPR_W-1:0]  PPR_RST      = PPR_W'(2);

	// Register indexes.
	localparam logic [IDX_W-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [IDX_W-1:0] REG_TIMEOUT  = 2'd1;
	localparam logic [IDX_W-1:0] REG_PPR      = 2'd2;

	// Input item kinds.
	localparam logic FUNC_EDGE   = 1'b0;
	localparam logic FUNC_UPDATE = 1'b1;

	// What the back end is to do with a queued command.
	typedef enum logic [1:0] {
		CMD_HOLD   = 2'd0,
		CMD_CLEAR  = 2'd1,
		CMD_DIVIDE = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [TIME_W-1:0]  period;
		logic               stopped;
		logic [DEN_W-1:0]   den;
	} cmd_t;

	typedef struct packed {
		logic [DEB_W-1:0]  debounce_us;
		logic [TIME_W-1:0] stop_timeout_us;
		logic [PPR_W-1:0]  pulses_per_rev;
	} cfg_t;

	// Queue handshake seen from either end.
	typedef struct packed {
		logic push;
	} qwr_t;

	typedef struct packed {
		logic empty;
	} qrd_t;

endpackage

`default_nettype wire

[rtl/core/tpt_if.sv]
`default_nettype none

// Input channel: one timestamped sensor edge or update request.
interface tpt_in_if;
	logic                        valid;
	logic                        ready;
	logic                        func;
	logic [tpt_pkg::TIME_W-1:0]  now_us;

	modport source (output valid, output func, output now_us, input ready);
	modport sink   (input valid, input func, input now_us, output ready);
endinterface

// Output channel: speed, period and stopped flag after each item.
interface tpt_out_if;
	logic                        valid;
	logic                        ready;
	logic [tpt_pkg::RPM_W-1:0]   rpm_q4;
	logic [tpt_pkg::TIME_W-1:0]  period_us;
	logic                        stopped;

	modport source (output valid, output rpm_q4, output period_us, output stopped,
		input ready);
	modport sink   (input valid, input rpm_q4, input period_us, input stopped,
		output ready);
endinterface

`default_nettype wire

[rtl/core/tpt_front.sv]
`default_nettype none

module tpt_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	tpt_in_if.sink             sample,
	input  tpt_pkg::cfg_t      cfg,
	input  wire logic          q_full,
	output tpt_pkg::qwr_t      qwr,
	output tpt_pkg::cmd_t      cmd
);

	logic [tpt_pkg::TIME_W-1:0] last_edge_q;
	logic [tpt_pkg::TIME_W-1:0] period_q;
	logic                       stop_q;

	logic [tpt_pkg::TIME_W-1:0] elapsed;
	logic [tpt_pkg::PPR_W-1:0]  ppr_eff;
	logic                       edge_ok;
	logic                       timed_out;
	logic                       accept;

	// A transaction is taken whenever the queue has room.
	assign sample.ready = !q_full;
	assign accept       = sample.valid && !q_full;
	assign qwr.push     = accept;

	// Classification of the item against the held edge time.
	assign elapsed   = sample.now_us - last_edge_q;
	assign edge_ok   = elapsed > {{(tpt_pkg::TIME_W - tpt_pkg::DEB_W){1'b0}}, cfg.debounce_us};
	assign timed_out = elapsed > cfg.stop_timeout_us;
	assign ppr_eff   = (cfg.pulses_per_rev == '0) ? tpt_pkg::PPR_W'(1) : cfg.pulses_per_rev;

	// Command for the back end, built from the state the item leaves behind.
	always_comb begin
		cmd.kind    = tpt_pkg::CMD_HOLD;
		cmd.period  = period_q;
		cmd.stopped = stop_q;
		cmd.den     = {{tpt_pkg::TIME_W{1'b0}}, ppr_eff} * {{tpt_pkg::PPR_W{1'b0}}, period_q};
		if (sample.func == tpt_pkg::FUNC_EDGE) begin
			if (edge_ok) begin
				cmd.period = elapsed;
			end
		end else begin
			if (timed_out) begin
				cmd.kind    = tpt_pkg::CMD_CLEAR;
				cmd.period  = '0;
				cmd.stopped = 1'b1;
			end else begin
				cmd.stopped = 1'b0;
				if (period_q != '0) begin
					cmd.kind = tpt_pkg::CMD_DIVIDE;
				end
			end
		end
	end

	// Edge time, period and stopped flag are updated as each item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_edge_q <= '0;
			period_q    <= '0;
			stop_q      <= 1'b0;
		end else if (accept) begin
			if (sample.func == tpt_pkg::FUNC_EDGE) begin
				if (edge_ok) begin
					period_q    <= elapsed;
					last_edge_q <= sample.now_us;
				end
			end else begin
				if (timed_out) begin
					period_q <= '0;
					stop_q   <= 1'b1;
				end else begin
					stop_q   <= 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/tpt_queue.sv]
`default_nettype none

module tpt_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  tpt_pkg::qwr_t      qwr,
	input  tpt_pkg::cmd_t      wr_cmd,
	input  wire logic          pop,
	output tpt_pkg::qrd_t      qrd,
	output logic               full,
	output tpt_pkg::cmd_t      rd_cmd
);

	tpt_pkg::cmd_t                mem_q [tpt_pkg::QUEUE_DEPTH];
	logic [tpt_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [tpt_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [tpt_pkg::QPTR_W:0]     count_q;
	logic                         do_push;
	logic                         do_pop;

	assign full      = count_q == (tpt_pkg::QPTR_W + 1)'(tpt_pkg::QUEUE_DEPTH);
	assign qrd.empty = count_q == '0;
	assign do_push   = qwr.push && !full;
	assign do_pop    = pop && !qrd.empty;
	assign rd_cmd    = mem_q[rd_ptr_q];

	// Command storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/tpt_back.sv]
`default_nettype none

module tpt_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  tpt_pkg::qrd_t      qrd,
	input  tpt_pkg::cmd_t      cmd,
	output logic               pop,
	tpt_out_if.source          result
);

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_DIV  = 2'b10
	} back_state_t;

	back_state_t                  state_q;
	logic [tpt_pkg::RPM_W-1:0]    speed_q;
	logic [tpt_pkg::DEN_W-1:0]    den_q;
	logic [tpt_pkg::NUM_W-1:0]    rem_q;
	logic [tpt_pkg::NUM_W-1:0]    quo_q;
	logic [tpt_pkg::CNT_W-1:0]    cnt_q;
	logic                         valid_q;
	logic [tpt_pkg::RPM_W-1:0]    rpm_q;
	logic [tpt_pkg::TIME_W-1:0]   res_period_q;
	logic                         res_stop_q;

	logic                         slot_free;
	logic [tpt_pkg::NUM_W:0]      trial;
	logic [tpt_pkg::DEN_W-1:0]    trial_ext;
	logic [tpt_pkg::DEN_W-1:0]    diff;
	logic                         ge;
	logic [tpt_pkg::NUM_W-1:0]    rem_next;
	logic [tpt_pkg::NUM_W-1:0]    quo_next;
	logic [tpt_pkg::RPM_W-1:0]    quo_sat;
	logic                         div_done;

	assign result.valid     = valid_q;
	assign result.rpm_q4    = rpm_q;
	assign result.period_us = res_period_q;
	assign result.stopped   = res_stop_q;

	// A command is started only when the result register is free or emptying.
	assign slot_free = !valid_q || result.ready;
	assign pop       = (state_q == B_IDLE) && !qrd.empty && slot_free;

	// One restoring division step: quotient bits enter the quotient register at the bottom.
	assign trial     = {rem_q, quo_q[tpt_pkg::NUM_W-1]};
	assign trial_ext = {{(tpt_pkg::DEN_W - tpt_pkg::NUM_W - 1){1'b0}}, trial};
	assign ge        = trial_ext >= den_q;
	assign diff      = trial_ext - den_q;
	assign rem_next  = ge ? diff[tpt_pkg::NUM_W-1:0] : trial[tpt_pkg::NUM_W-1:0];
	assign quo_next  = {quo_q[tpt_pkg::NUM_W-2:0], ge};
	assign quo_sat   = (quo_next[tpt_pkg::NUM_W-1:tpt_pkg::RPM_W] != '0) ?
		tpt_pkg::RPM_MAX : quo_next[tpt_pkg::RPM_W-1:0];
	assign div_done  = (state_q == B_DIV) && (cnt_q == tpt_pkg::DIV_LAST);

	// Sequencer, speed register and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			speed_q <= '0;
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (valid_q && result.ready) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						case (cmd.kind)
							tpt_pkg::CMD_CLEAR: begin
								speed_q <= '0;
								valid_q <= 1'b1;
							end
							tpt_pkg::CMD_DIVIDE: begin
								cnt_q   <= '0;
								state_q <= B_DIV;
							end
							default: begin
								valid_q <= 1'b1;
							end
						endcase
					end
				end
				B_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (div_done) begin
						speed_q <= quo_sat;
						valid_q <= 1'b1;
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	// Divider datapath and result payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			res_period_q <= cmd.period;
			res_stop_q   <= cmd.stopped;
			den_q        <= cmd.den;
			rem_q        <= '0;
			quo_q        <= tpt_pkg::RPM_Q4_NUM;
			if (cmd.kind == tpt_pkg::CMD_CLEAR) begin
				rpm_q <= '0;
			end else begin
				rpm_q <= speed_q;
			end
		end else if (state_q == B_DIV) begin
			rem_q <= rem_next;
			quo_q <= quo_next;
			if (div_done) begin
				rpm_q <= quo_sat;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/pulse_period_tachometer_core.sv]
`default_nettype none

// Channel   Role    Payload                          Transaction
// sample    sink    func, now_us                     valid && ready
// result    source  rpm_q4, period_us, stopped       valid && ready
// cfg       write   cfg_index, cfg_data              cfg_we high
//
// Items enter a two-entry command queue at one per cycle while it has room.
// Edges and held or cleared updates leave through the queue and the result register;
// an update with a held period first runs the 30-step restoring divider in the back end.
// Reset is asynchronous and restores the configuration reset values.
// A stalled result holds the back end; the front keeps taking items until the
// queue is full.

module pulse_period_tachometer_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	tpt_in_if.sink                             sample,
	tpt_out_if.source                          result,
	input  wire logic                          cfg_we,
	input  wire logic [tpt_pkg::IDX_W-1:0]     cfg_index,
	input  wire logic [tpt_pkg::DATA_W-1:0]    cfg_data
);

	tpt_pkg::cfg_t  cfg_q;
	tpt_pkg::qwr_t  qwr;
	tpt_pkg::qrd_t  qrd;
	tpt_pkg::cmd_t  wr_cmd;
	tpt_pkg::cmd_t  rd_cmd;
	logic           q_full;
	logic           pop;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_us     <= tpt_pkg::DEBOUNCE_RST;
			cfg_q.stop_timeout_us <= tpt_pkg::TIMEOUT_RST;
			cfg_q.pulses_per_rev  <= tpt_pkg::PPR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tpt_pkg::REG_DEBOUNCE: cfg_q.debounce_us     <= cfg_data[tpt_pkg::DEB_W-1:0];
				tpt_pkg::REG_TIMEOUT:  cfg_q.stop_timeout_us <= cfg_data[tpt_pkg::TIME_W-1:0];
				tpt_pkg::REG_PPR:      cfg_q.pulses_per_rev  <= cfg_data[tpt_pkg::PPR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tpt_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.cfg    (cfg_q),
		.q_full (q_full),
		.qwr    (qwr),
		.cmd    (wr_cmd)
	);

	tpt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.qwr    (qwr),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.qrd    (qrd),
		.full   (q_full),
		.rd_cmd (rd_cmd)
	);

	tpt_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qrd    (qrd),
		.cmd    (rd_cmd),
		.pop    (pop),
		.result (result)
	);

endmodule

`default_nettype wire

[rtl/core/tpt_checker.sv]
`default_nettype none

module tpt_checker (
	input  wire logic    clk,
	input  wire logic    arst_n,
	tpt_in_if.sink       sample,
	tpt_out_if.source    result
);

	logic [2:0] pending_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = sample.valid && sample.ready;
	assign out_acc = result.valid && result.ready;

	// Items taken whose result has not yet been delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid)
		else $error("result valid dropped during a stall");

	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=>
			$stable(result.rpm_q4) && $stable(result.period_us) && $stable(result.stopped))
		else $error("result payload changed during a stall");

	a_stopped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.stopped |-> result.rpm_q4 == '0)
		else $error("speed not zero while stopped");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pending_q != '0)
		else $error("result delivered with no item outstanding");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd4)
		else $error("too many items outstanding");

endmodule

bind pulse_period_tachometer_core tpt_checker u_tpt_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.sample (sample),
	.result (result)
);

`default_nettype wire

[dv/tb_top.sv]
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// One sample as it enters the block, and one reading as it leaves.
	typedef struct packed {
		logic                       func;
		logic [tpt_pkg::TIME_W-1:0] now_us;
	} tach_sample_t;

	typedef struct packed {
		logic [tpt_pkg::RPM_W-1:0]  rpm_q4;
		logic [tpt_pkg::TIME_W-1:0] period_us;
		logic                       stopped;
	} tach_reading_t;

	localparam logic [63:0]               Q4_RPM_NUMERATOR = 64'd960000000;
	localparam logic [tpt_pkg::IDX_W-1:0] REG_SPARE        = 2'd3;
	localparam int unsigned               LONG_HOLD_AT     = 300;
	localparam int unsigned               LONG_HOLD_CYCLES = 400;
	localparam int unsigned               PHASE_COUNT      = 8;
	localparam int unsigned               PHASE_SAMPLES    = 135;

	logic clk;
	logic arst_n = 1'b0;

	logic                       in_valid = 1'b0;
	logic                       in_func = 1'b0;
	logic [tpt_pkg::TIME_W-1:0] in_now = '0;
	logic                       out_ready = 1'b0;

	logic                       cfg_we = 1'b0;
	logic [tpt_pkg::IDX_W-1:0]  cfg_index = '0;
	logic [tpt_pkg::DATA_W-1:0] cfg_data = '0;

	tpt_in_if  sample_ch ();
	tpt_out_if result_ch ();

	assign sample_ch.valid  = in_valid;
	assign sample_ch.func   = in_func;
	assign sample_ch.now_us = in_now;
	assign result_ch.ready  = out_ready;

	pulse_period_tachometer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow configuration and tachometer state.
	logic [tpt_pkg::DEB_W-1:0]  sh_deb = tpt_pkg::DEBOUNCE_RST;
	logic [tpt_pkg::TIME_W-1:0] sh_tmo = tpt_pkg::TIMEOUT_RST;
	logic [tpt_pkg::PPR_W-1:0]  sh_ppr = tpt_pkg::PPR_RST;

	logic [tpt_pkg::TIME_W-1:0] last_edge_us = '0;
	logic [tpt_pkg::TIME_W-1:0] held_period = '0;
	logic [tpt_pkg::RPM_W-1:0]  held_speed = '0;
	logic                       stop_seen = 1'b0;

	tach_sample_t  sample_q[$];
	tach_reading_t reading_q[$];
	tach_sample_t  cur_sample;

	int unsigned   mismatches = 0;
	int unsigned   sample_count = 0;
	int unsigned   readings_seen = 0;
	int unsigned   send_wait = 0;
	int unsigned   ready_wait = 0;
	bit            long_hold_done = 1'b0;
	bit            no_idle = 1'b0;
	logic [tpt_pkg::TIME_W-1:0] t_now = '0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Advance the shadow tachometer by one sample and return the reading it yields.
	function automatic tach_reading_t tach_advance(tach_sample_t s);
		logic [tpt_pkg::TIME_W-1:0] elapsed;
		logic [tpt_pkg::PPR_W-1:0]  ppr_eff;
		logic [63:0]                denom;
		logic [63:0]                quot;
		tach_reading_t              r;
		elapsed = s.now_us - last_edge_us;
		if (s.func == tpt_pkg::FUNC_EDGE) begin
			if (elapsed > tpt_pkg::TIME_W'(sh_deb)) begin
				held_period  = elapsed;
				last_edge_us = s.now_us;
			end
		end else if (elapsed > sh_tmo) begin
			held_period = '0;
			held_speed  = '0;
			stop_seen   = 1'b1;
		end else begin
			stop_seen = 1'b0;
			if (held_period != '0) begin
				ppr_eff    = (sh_ppr == '0) ? tpt_pkg::PPR_W'(1) : sh_ppr;
				denom      = 64'(ppr_eff) * 64'(held_period);
				quot       = Q4_RPM_NUMERATOR / denom;
				held_speed = (quot > 64'(tpt_pkg::RPM_MAX)) ?
					tpt_pkg::RPM_MAX : quot[tpt_pkg::RPM_W-1:0];
			end
		end
		r.rpm_q4    = held_speed;
		r.period_us = held_period;
		r.stopped   = stop_seen;
		return r;
	endfunction

	// Gap before the next transaction: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 45)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Sender: predicts each accepted transaction, then offers the next sample.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && sample_ch.ready)
				reading_q.push_back(tach_advance(cur_sample));
			if (!in_valid || sample_ch.ready) begin
				if (send_wait > 0) begin
					send_wait--;
					in_valid <= 1'b0;
				end else if (sample_q.size() != 0) begin
					cur_sample = sample_q.pop_front();
					in_func   <= cur_sample.func;
					in_now    <= cur_sample.now_us;
					in_valid  <= 1'b1;
					send_wait = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off to back the block up.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (result_ch.valid && out_ready) begin
				readings_seen++;
				ready_wait = pick_gap();
			end
			if (!long_hold_done && readings_seen >= LONG_HOLD_AT) begin
				long_hold_done = 1'b1;
				ready_wait = LONG_HOLD_CYCLES;
			end
			if (ready_wait > 0) begin
				ready_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Compare every accepted reading against the oldest prediction.
	always @(posedge clk) begin
		tach_reading_t want;
		tach_reading_t got;
		if (arst_n && result_ch.valid && out_ready) begin
			got.rpm_q4    = result_ch.rpm_q4;
			got.period_us = result_ch.period_us;
			got.stopped   = result_ch.stopped;
			if (reading_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected reading rpm_q4=%0d period_us=%0d stopped=%0b",
						$realtime, got.rpm_q4, got.period_us, got.stopped);
			end else begin
				want = reading_q.pop_front();
				if (got.rpm_q4 !== want.rpm_q4 || got.period_us !== want.period_us ||
					got.stopped !== want.stopped) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: exp/act rpm_q4 %0d/%0d period_us %0d/%0d stopped %0b/%0b",
							$realtime, want.rpm_q4, got.rpm_q4, want.period_us, got.period_us,
							want.stopped, got.stopped);
				end
			end
		end
	end

	task automatic queue_sample(logic func, logic [tpt_pkg::TIME_W-1:0] now_us);
		tach_sample_t s;
		s.func   = func;
		s.now_us = now_us;
		sample_q.push_back(s);
		sample_count++;
	endtask

	// Register write; the block must be idle.
	task automatic write_reg(logic [tpt_pkg::IDX_W-1:0] idx, logic [tpt_pkg::DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			tpt_pkg::REG_DEBOUNCE: sh_deb = data[tpt_pkg::DEB_W-1:0];
			tpt_pkg::REG_TIMEOUT:  sh_tmo = data[tpt_pkg::TIME_W-1:0];
			tpt_pkg::REG_PPR:      sh_ppr = data[tpt_pkg::PPR_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every queued sample has gone in and every reading has come out.
	task automatic drain();
		while (sample_q.size() != 0 || in_valid || reading_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// A spinning shaft: regular edges with jitter, some chatter, updates between
	// them and now and then an update right at the stop timeout.
	task automatic queue_shaft_run();
		logic [tpt_pkg::TIME_W-1:0] period;
		logic [tpt_pkg::TIME_W-1:0] jitter;
		int unsigned                sel;
		sel = $urandom_range(0, 9);
		if (sel < 2)
			period = tpt_pkg::TIME_W'(sh_deb) + $urandom_range(1, 64);
		else if (sel < 7)
			period = tpt_pkg::TIME_W'(sh_deb) + $urandom_range(1, 20000);
		else if (sel < 9)
			period = $urandom_range(1, 2000000);
		else
			period = $urandom();
		repeat ($urandom_range(2, 8)) begin
			jitter = $urandom_range(0, period >> 3);
			t_now  = t_now + period + jitter;
			queue_sample(tpt_pkg::FUNC_EDGE, t_now);
			if ($urandom_range(0, 3) == 0)
				queue_sample(tpt_pkg::FUNC_EDGE, t_now + $urandom_range(0, sh_deb));
			repeat ($urandom_range(0, 2))
				queue_sample(tpt_pkg::FUNC_UPDATE, t_now + $urandom_range(0, period >> 1));
		end
		if ($urandom_range(0, 3) == 0)
			queue_sample(tpt_pkg::FUNC_UPDATE, t_now + sh_tmo + $urandom_range(0, 2));
	endtask

	// Arbitrary samples and jumps of the time base, including near the wrap.
	task automatic queue_noise();
		repeat ($urandom_range(1, 6))
			queue_sample($urandom_range(0, 1) ? tpt_pkg::FUNC_UPDATE : tpt_pkg::FUNC_EDGE,
				$urandom());
		if ($urandom_range(0, 1) == 0)
			t_now = $urandom();
		else
			t_now = 32'hFFFF_0000 + $urandom_range(0, 32'hFFFF);
	endtask

	initial begin
		int unsigned phase_end;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration: zero period, debounce boundary, chatter,
		// timeout boundary, edge while stopped and timestamp wrap.
		queue_sample(tpt_pkg::FUNC_UPDATE, 32'd0);
		queue_sample(tpt_pkg::FUNC_EDGE,   32'd2000);
		queue_sample(tpt_pkg::FUNC_EDGE,   32'd2001);
		queue_sample(tpt_pkg::FUNC_UPDATE, 32'd2500);
		queue_sample(tpt_pkg::FUNC_EDGE,   32'd3000);
		queue_sample(tpt_pkg::FUNC_UPDATE, 32'd1002001);
		queue_sample(tpt_pkg::FUNC_UPDATE, 32'd1002002);
		queue_sample(tpt_pkg::FUNC_EDGE,   32'hFFFF_FFF0);
		queue_sample(tpt_pkg::FUNC_UPDATE, 32'hFFFF_FFF5);
		queue_sample(tpt_pkg::FUNC_EDGE,   32'h0000_0800);
		queue_sample(tpt_pkg::FUNC_UPDATE, 32'h0000_0900);
		drain();

		// No debounce, pulses per revolution of zero taken as one: saturation.
		write_reg(tpt_pkg::REG_DEBOUNCE, 32'd0);
		write_reg(tpt_pkg::REG_PPR, 32'hFFFF_FFE0);
		queue_sample(tpt_pkg::FUNC_EDGE,   32'h0000_1000);
		queue_sample(tpt_pkg::FUNC_EDGE,   32'h0000_1000);
		queue_sample(tpt_pkg::FUNC_EDGE,   32'h0000_1001);
		queue_sample(tpt_pkg::FUNC_UPDATE, 32'h0000_1001);
		drain();

		// Largest pulse count and a zero stop timeout.
		write_reg(tpt_pkg::REG_PPR, 32'd31);
		write_reg(tpt_pkg::REG_TIMEOUT, 32'd0);
		queue_sample(tpt_pkg::FUNC_UPDATE, 32'h0000_1001);
		queue_sample(tpt_pkg::FUNC_UPDATE, 32'h0000_1002);
		queue_sample(tpt_pkg::FUNC_EDGE,   32'h0000_1066);
		queue_sample(tpt_pkg::FUNC_UPDATE, 32'h0000_1066);
		drain();

		// Longest debounce and timeout; the spare index must change nothing.
		write_reg(tpt_pkg::REG_TIMEOUT, 32'hFFFF_FFFF);
		write_reg(tpt_pkg::REG_DEBOUNCE, 32'hABCD_FFFF);
		write_reg(tpt_pkg::REG_PPR, 32'd16);
		write_reg(REG_SPARE, $urandom());
		queue_sample(tpt_pkg::FUNC_UPDATE, 32'h8000_1066);
		queue_sample(tpt_pkg::FUNC_EDGE,   32'h0000_1066 + 32'd65535);
		queue_sample(tpt_pkg::FUNC_EDGE,   32'h0000_1066 + 32'd65536);
		queue_sample(tpt_pkg::FUNC_UPDATE, 32'h0000_1065);
		drain();

		// Random phases, each under its own configuration.
		for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
			if (p == 0) begin
				write_reg(tpt_pkg::REG_DEBOUNCE, 32'd0);
				write_reg(tpt_pkg::REG_TIMEOUT, 32'd0);
				write_reg(tpt_pkg::REG_PPR, 32'd1);
			end else if (p == PHASE_COUNT - 1) begin
				write_reg(tpt_pkg::REG_DEBOUNCE, 32'd65535);
				write_reg(tpt_pkg::REG_TIMEOUT, 32'hFFFF_FFFF);
				write_reg(tpt_pkg::REG_PPR, 32'd16);
			end else begin
				write_reg(tpt_pkg::REG_DEBOUNCE, ($urandom_range(0, 3) == 0) ?
					$urandom() : $urandom_range(0, 4000));
				write_reg(tpt_pkg::REG_TIMEOUT, ($urandom_range(0, 2) == 0) ?
					$urandom() : $urandom_range(1000, 3000000));
				write_reg(tpt_pkg::REG_PPR, ($urandom_range(0, 3) == 0) ?
					$urandom() : $urandom_range(1, 16));
			end
			no_idle = ($urandom_range(0, 3) == 0);
			t_now = $urandom();
			phase_end = sample_count + PHASE_SAMPLES;
			while (sample_count < phase_end) begin
				if ($urandom_range(0, 4) == 0)
					queue_noise();
				else
					queue_shaft_run();
			end
			drain();
		end

		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog.
	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire
